// File: rtl/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

  localparam int FIELD_W           = 16;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 32;
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_RED = 3'd4,
    OP_GT  = 3'd5
  } rau_op_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_ARITH,
    K_CMP
  } rau_kind_t;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } rau_req_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic signed [RES_DEN_W-1:0] res_den;
    logic                        greater;
    logic                        zero_gcd_error;
  } rau_rsp_t;

  typedef struct packed {
    rau_kind_t kind;
    logic      greater;
  } rau_ctl_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } rau_front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ALIGN,
    B_SUB,
    B_DIV,
    B_OUT
  } rau_back_state_t;

endpackage

// File: rtl/rau_front.sv
// Front end: accepts a word, forms the cross products and classifies the operation.
module rau_front #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF,
  parameter int IW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::rau_req_t    req,
  input  logic                 req_valid,
  output logic                 req_ready,
  output rau_pkg::rau_ctl_t    push_ctl,
  output logic signed [IW-1:0] push_n,
  output logic signed [IW-1:0] push_d,
  output logic                 push_valid,
  input  logic                 push_ready
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  rau_front_state_t state, state_next;
  logic [1:0]           cnt;
  logic [2:0]           op;
  logic signed [W-1:0]  an, ad, bn, bd;
  logic signed [W-1:0]  mx, my;
  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] p0, p1, p2;
  logic signed [2*W:0]  sum_add, sum_sub;
  logic [31:0]          ext_an, ext_ad, ext_bn, ext_bd;

  // Fields are zero-extended to 32 bits, and the low operand-width bits are kept as signed values.
  assign ext_an = {{(32 - FIELD_W){1'b0}}, req.a_num};
  assign ext_ad = {{(32 - FIELD_W){1'b0}}, req.a_den};
  assign ext_bn = {{(32 - FIELD_W){1'b0}}, req.b_num};
  assign ext_bd = {{(32 - FIELD_W){1'b0}}, req.b_den};

  always_comb begin
    unique case (cnt)
      2'd0: begin
        mx = an;
        my = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        mx = ad;
        my = bn;
      end
      default: begin
        mx = ad;
        my = bd;
      end
    endcase
  end

  assign prod = mx * my;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (req_valid) state_next = F_MUL;
      F_MUL:   if (cnt == 2'd2) state_next = F_PUSH;
      F_PUSH:  if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  assign sum_add = (2*W+1)'(p0) + (2*W+1)'(p1);
  assign sum_sub = (2*W+1)'(p0) - (2*W+1)'(p1);

  always_comb begin
    req_ready  = (state == F_IDLE);
    push_valid = (state == F_PUSH);
    push_ctl.greater = 1'b0;
    push_ctl.kind    = K_ARITH;
    push_n = '0;
    push_d = IW'(p2);
    unique case (op)
      OP_ADD: push_n = sum_add[IW-1:0];
      OP_SUB: push_n = sum_sub[IW-1:0];
      OP_MUL: push_n = IW'(p0);
      OP_DIV: begin
        push_n = IW'(p0);
        push_d = IW'(p1);
      end
      OP_RED: begin
        push_n = IW'(an);
        push_d = IW'(ad);
      end
      OP_GT: begin
        push_ctl.kind    = K_CMP;
        push_ctl.greater = (p0 > p1);
        push_d           = '0;
      end
      default: begin
        push_ctl.kind = K_NONE;
        push_d        = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE) cnt <= '0;
      else if (state == F_MUL) cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && req_valid) begin
      op <= req.op;
      an <= ext_an[W-1:0];
      ad <= ext_ad[W-1:0];
      bn <= ext_bn[W-1:0];
      bd <= ext_bd[W-1:0];
    end
    if (state == F_MUL) begin
      unique case (cnt)
        2'd0:    p0 <= prod;
        2'd1:    p1 <= prod;
        default: p2 <= prod;
      endcase
    end
  end

endmodule

// File: rtl/rau_queue.sv
// Short queue that decouples the front end from the reduction engine.
module rau_queue #(
  parameter int IW    = 33,
  parameter int DEPTH = rau_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::rau_ctl_t    push_ctl,
  input  logic signed [IW-1:0] push_n,
  input  logic signed [IW-1:0] push_d,
  input  logic                 push_valid,
  output logic                 push_ready,
  output rau_pkg::rau_ctl_t    pop_ctl,
  output logic signed [IW-1:0] pop_n,
  output logic signed [IW-1:0] pop_d,
  output logic                 pop_valid,
  input  logic                 pop_ready
);
  import rau_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rau_ctl_t             ent_ctl [DEPTH];
  logic signed [IW-1:0] ent_n   [DEPTH];
  logic signed [IW-1:0] ent_d   [DEPTH];
  logic [PW-1:0]        wptr, rptr;
  logic [CW-1:0]        count;
  logic                 do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  assign pop_ctl = ent_ctl[rptr];
  assign pop_n   = ent_n[rptr];
  assign pop_d   = ent_d[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (do_pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_ctl[wptr] <= push_ctl;
      ent_n[wptr]   <= push_n;
      ent_d[wptr]   <= push_d;
    end
  end

endmodule

// File: rtl/rau_back.sv
// Back end: Euclid GCD by shift-subtract remainders, exact division and the result register.
module rau_back #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF,
  parameter int IW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::rau_ctl_t    pop_ctl,
  input  logic signed [IW-1:0] pop_n,
  input  logic signed [IW-1:0] pop_d,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  output rau_pkg::rau_rsp_t    rsp,
  output logic                 rsp_valid,
  input  logic                 rsp_ready
);
  import rau_pkg::*;

  localparam int DCW = $clog2(IW + 1);

  rau_back_state_t state, state_next;
  rau_ctl_t        ctl;
  logic            n_neg, d_neg, g_neg, err, par;
  logic [IW-1:0]   a_rem, b_div, d_sh;
  logic [IW-1:0]   sn, sd;
  logic [IW:0]     rn, rd;
  logic [DCW-1:0]  dcnt;
  logic [IW-1:0]   nm_in, dm_in;
  logic [IW-1:0]   a_new;
  logic            rem_done;
  logic [IW:0]     tn, td;
  logic            bit_n, bit_d;
  logic            out_load;
  logic signed [IW-1:0] qn, qd;
  logic signed [63:0]   qn64, qd64;
  rau_rsp_t        rsp_next;

  assign nm_in = pop_n[IW-1] ? IW'(-pop_n) : pop_n;
  assign dm_in = pop_d[IW-1] ? IW'(-pop_d) : pop_d;

  assign a_new    = (a_rem >= d_sh) ? a_rem - d_sh : a_rem;
  assign rem_done = (d_sh == b_div);

  assign tn    = {rn[IW-1:0], sn[IW-1]};
  assign td    = {rd[IW-1:0], sd[IW-1]};
  assign bit_n = (tn >= {1'b0, b_div});
  assign bit_d = (td >= {1'b0, b_div});

  assign qn   = (n_neg ^ g_neg) ? -signed'(sn) : signed'(sn);
  assign qd   = (d_neg ^ g_neg) ? -signed'(sd) : signed'(sd);
  assign qn64 = 64'(qn);
  assign qd64 = 64'(qd);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_ctl.kind != K_ARITH || (pop_n == '0 && pop_d == '0)) state_next = B_OUT;
          else if (pop_d == '0) state_next = B_DIV;
          else state_next = B_ALIGN;
        end
      end
      B_ALIGN: if (d_sh > (a_rem >> 1)) state_next = B_SUB;
      B_SUB:   if (rem_done) state_next = (a_new == '0) ? B_DIV : B_ALIGN;
      B_DIV:   if (dcnt == DCW'(1)) state_next = B_OUT;
      B_OUT:   if (!rsp_valid || rsp_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state == B_IDLE);
    out_load  = (state == B_OUT) && (!rsp_valid || rsp_ready);
    rsp_next  = '0;
    unique case (ctl.kind)
      K_CMP:   rsp_next.greater = ctl.greater;
      K_ARITH: begin
        if (err) begin
          rsp_next.zero_gcd_error = 1'b1;
        end else begin
          rsp_next.res_num = qn64[RES_NUM_W-1:0];
          rsp_next.res_den = qd64[RES_DEN_W-1:0];
        end
      end
      default: rsp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rsp <= rsp_next;
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          ctl   <= pop_ctl;
          n_neg <= pop_n[IW-1];
          d_neg <= pop_d[IW-1];
          g_neg <= pop_n[IW-1];
          err   <= (pop_n == '0 && pop_d == '0);
          par   <= 1'b0;
          a_rem <= nm_in;
          b_div <= (pop_d == '0) ? nm_in : dm_in;
          d_sh  <= dm_in;
          sn    <= nm_in;
          sd    <= dm_in;
          rn    <= '0;
          rd    <= '0;
          dcnt  <= DCW'(IW);
        end
      end
      B_ALIGN: begin
        if (d_sh <= (a_rem >> 1)) d_sh <= d_sh << 1;
      end
      B_SUB: begin
        if (rem_done) begin
          par <= ~par;
          // The divisor of this step becomes the dividend of the next one.
          if (a_new == '0) begin
            g_neg <= par ? n_neg : d_neg;
          end else begin
            a_rem <= b_div;
            b_div <= a_new;
            d_sh  <= a_new;
          end
        end else begin
          a_rem <= a_new;
          d_sh  <= d_sh >> 1;
        end
      end
      B_DIV: begin
        rn   <= bit_n ? tn - {1'b0, b_div} : tn;
        rd   <= bit_d ? td - {1'b0, b_div} : td;
        sn   <= {sn[IW-2:0], bit_n};
        sd   <= {sd[IW-2:0], bit_d};
        dcnt <= dcnt - DCW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: front end, queue and reduction engine.
// Each request word carries two signed fractions and an opcode (add, subtract, multiply,
// divide, reduce the first fraction, greater compare) and yields exactly one response
// word. The front end takes a word only when it is idle, then forms the three cross
// products one after another on its single multiplier and hands the raw fraction to a
// two-entry queue, waiting while the queue is full, after which it can take the next word.
// The back end reduces the raw fraction by a Euclid GCD whose remainders come from a
// shift-and-subtract unit: each remainder step first shifts the divisor up to align it
// with the dividend and then shifts it back down, subtracting wherever it fits. The
// numerator and denominator are then divided by the GCD in parallel, one quotient bit
// per cycle, over the internal width (33 bits at the default operand width). Compare
// and unused opcodes skip the remainder loop and the divider. The GCD keeps the sign
// of the truncated remainder chain, so a negative GCD can flip the signs of the reduced
// result. When numerator and denominator are both zero the response is zero over zero
// with the error flag set. The result is held in an output register, so the back end
// works on the next queued word while the previous response waits.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::rau_req_t req,
  input  logic              req_valid,
  output logic              req_ready,
  output rau_pkg::rau_rsp_t rsp,
  output logic              rsp_valid,
  input  logic              rsp_ready
);
  import rau_pkg::*;

  // Internal width of the raw fraction: products plus one carry bit, capped at 64 bits.
  localparam int IW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;

  rau_ctl_t             push_ctl, pop_ctl;
  logic signed [IW-1:0] push_n, push_d, pop_n, pop_d;
  logic                 push_valid, push_ready, pop_valid, pop_ready;

  rau_front #(
    .OPERAND_WIDTH(OPERAND_WIDTH),
    .IW(IW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .req(req),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .push_ctl(push_ctl),
    .push_n(push_n),
    .push_d(push_d),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  rau_queue #(
    .IW(IW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_ctl(push_ctl),
    .push_n(push_n),
    .push_d(push_d),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_ctl(pop_ctl),
    .pop_n(pop_n),
    .pop_d(pop_d),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready)
  );

  rau_back #(
    .OPERAND_WIDTH(OPERAND_WIDTH),
    .IW(IW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .pop_ctl(pop_ctl),
    .pop_n(pop_n),
    .pop_d(pop_d),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .rsp(rsp),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready)
  );

endmodule

// File: tb/tb_rational_arith_unit.sv
// Self-checking testbench for the rational arithmetic unit.
module tb_rational_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  // Opcodes 6 and 7 have no package name; the block must answer them with an all-zero word.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 800;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;

  // The scoreboard works out the response that each accepted request must produce and
  // compares the responses that come back in order against those expectations.
  class fraction_scoreboard;
    rau_rsp_t expected_q[$];
    int mismatches;
    int checked;
    int zero_gcd_seen;
    int negative_gcd_seen;

    function new();
      mismatches = 0;
      checked = 0;
      zero_gcd_seen = 0;
      negative_gcd_seen = 0;
    endfunction

    // Predicts the reduced fraction for one accepted request word.
    function void note_request(rau_req_t r);
      rau_rsp_t e;
      longint an, ad, bn, bd, num, den, x, y, rem, g, qn, qd;
      bit reduce;
      an = longint'(r.a_num);
      ad = longint'(r.a_den);
      bn = longint'(r.b_num);
      bd = longint'(r.b_den);
      e = '0;
      reduce = 1'b1;
      num = 0;
      den = 0;
      case (r.op)
        OP_ADD: begin
          num = an * bd + ad * bn;
          den = ad * bd;
        end
        OP_SUB: begin
          num = an * bd - ad * bn;
          den = ad * bd;
        end
        OP_MUL: begin
          num = an * bn;
          den = ad * bd;
        end
        OP_DIV: begin
          num = an * bd;
          den = ad * bn;
        end
        OP_RED: begin
          num = an;
          den = ad;
        end
        OP_GT: begin
          e.greater = (an * bd > ad * bn);
          reduce = 1'b0;
        end
        default: reduce = 1'b0;
      endcase
      if (reduce) begin
        // Euclid with truncated remainders, so the sign of the GCD is whatever falls out.
        x = num;
        y = den;
        while (y != 0) begin
          rem = (y == 1 || y == -1) ? 0 : x % y;
          x = y;
          y = rem;
        end
        g = x;
        if (g == 0) begin
          e.zero_gcd_error = 1'b1;
          zero_gcd_seen++;
        end else begin
          if (g < 0) negative_gcd_seen++;
          qn = (g == -1) ? -num : num / g;
          qd = (g == -1) ? -den : den / g;
          e.res_num = qn[RES_NUM_W-1:0];
          e.res_den = qd[RES_DEN_W-1:0];
        end
      end
      expected_q.push_back(e);
    endfunction

    // Compares one accepted response word with the oldest expectation.
    function void check_response(rau_rsp_t got);
      rau_rsp_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: response %h arrived with nothing expected", got);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.res_num !== e.res_num || got.res_den !== e.res_den ||
          got.greater !== e.greater || got.zero_gcd_error !== e.zero_gcd_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d expected num=%0d den=%0d gt=%b err=%b, got num=%0d den=%0d gt=%b err=%b",
                   checked, e.res_num, e.res_den, e.greater, e.zero_gcd_error,
                   got.res_num, got.res_den, got.greater, got.zero_gcd_error);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst;
  rau_req_t req;
  logic     req_valid;
  logic     req_ready;
  rau_rsp_t rsp;
  logic     rsp_valid;
  logic     rsp_ready;

  fraction_scoreboard sb;

  // Flags shared between the sender, the receiver and the watchdog.
  bit quiet_phase;   // no idling on either side once set
  bit hold_request;  // asks the receiver for one long hold-off
  int idle_cycles;
  int words_sent;

  rational_arith_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one request word at a falling edge and holds it until the block takes it.
  // Valid is left high afterwards, so the next word can follow without a gap.
  task automatic send_word(input logic [2:0] op, input logic [15:0] an, input logic [15:0] ad,
                           input logic [15:0] bn, input logic [15:0] bd);
    @(negedge clk);
    req.op    <= op;
    req.a_num <= an;
    req.a_den <= ad;
    req.b_num <= bn;
    req.b_den <= bd;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(req);
    words_sent++;
  endtask

  // Drops valid for a burst of random length, now and then.
  task automatic maybe_idle_sender();
    int n;
    if (quiet_phase || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 5);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Denominator and numerator values: mostly small, sometimes full range or corner values.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($signed($urandom_range(0, 40)) - 20);
      4:          return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      5:          return 16'd0;
      6:          return 16'($signed($urandom_range(0, 600)) - 300);
      default:    return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_word();
    logic [2:0] op;
    logic [15:0] k;
    op = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    if ($urandom_range(0, 7) == 0) begin
      // Fractions with a shared factor exercise the reduction path more deeply.
      k = 16'($urandom_range(2, 60));
      send_word(op, 16'($signed(k) * ($signed($urandom_range(0, 100)) - 50)),
                16'($signed(k) * $urandom_range(1, 90)), pick_value(), pick_value());
    end else begin
      send_word(op, pick_value(), pick_value(), pick_value(), pick_value());
    end
  endtask

  // Stimulus: directed corners, then random words with pauses and a long receiver hold.
  initial begin
    sb = new();
    rst = 1'b1;
    req = '0;
    req_valid = 1'b0;
    quiet_phase = 1'b0;
    hold_request = 1'b0;
    words_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every opcode on a plain pair of fractions.
    send_word(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_word(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd3);
    send_word(OP_MUL, 16'd2, 16'd3, 16'd9, 16'd4);
    send_word(OP_DIV, 16'd2, 16'd3, 16'd4, 16'd9);
    send_word(OP_RED, 16'd12, 16'd18, 16'd0, 16'd0);
    send_word(OP_GT,  16'd1, 16'd2, 16'd1, 16'd3);
    send_word(OP_GT,  16'd1, 16'd3, 16'd1, 16'd2);
    send_word(OP_SPARE_LO, 16'd5, 16'd7, 16'd3, 16'd2);
    send_word(OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Zero over zero, both from reduce and from cross products with zero denominators or numerators.
    send_word(OP_RED, 16'd0, 16'd0, 16'd7, 16'd7);
    send_word(OP_ADD, 16'd3, 16'd0, 16'd4, 16'd0);
    send_word(OP_DIV, 16'd0, 16'd5, 16'd0, 16'd9);
    // Negative GCDs, including one of minus one.
    send_word(OP_RED, 16'hFFFA, 16'hFFF7, 16'd0, 16'd0);
    send_word(OP_RED, 16'd5, 16'hFFFF, 16'd0, 16'd0);
    send_word(OP_RED, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    // Field extremes.
    send_word(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_ADD, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(OP_SUB, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_word(OP_DIV, 16'h7FFF, 16'h0001, 16'h8000, 16'h7FFF);
    send_word(OP_GT,  16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_word(OP_GT,  16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_word(OP_RED, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    send_word(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 150) hold_request = 1'b1;
      if (i == 300 || i == 550) begin
        // Let the block drain completely before going on.
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (i == RANDOM_WORDS - 120) quiet_phase = 1'b1;
      send_random_word();
      maybe_idle_sender();
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d request words over all opcodes, %0d responses checked,",
             words_sent, sb.checked);
    $display("  %0d zero-over-zero errors and %0d negative GCD reductions predicted.",
             sb.zero_gcd_seen, sb.negative_gcd_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none in the quiet phase.
  initial begin
    int n;
    rsp_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(negedge clk);
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        rsp_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Response monitor and watchdog, both sampling at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
